>>> src/tqd_pkg.sv
`default_nettype none

package tqd_pkg;

	// field widths
	localparam int COORD_W = 16;
	localparam int PRES_W  = 16;
	localparam int THR_W   = 10;
	localparam int QUAD_W  = 3;
	localparam int CFG_IDX_W = 2;

	// operation codes carried in s_tuser
	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_FORCE    = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COORD_THR    = 2'd1;

	// register reset values
	localparam logic [THR_W-1:0] PRESSURE_THR_RST = 10'd5;
	localparam logic [THR_W-1:0] COORD_THR_RST    = 10'd10;

	// quadrant code for "no quadrant"
	localparam logic [QUAD_W-1:0] QUAD_NONE = 3'd4;

	// one input item
	typedef struct packed {
		logic                      op;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic        [PRES_W-1:0]  p;
	} item_t;

	// one result item
	typedef struct packed {
		logic              pressed;
		logic [1:0]        button;
		logic [QUAD_W-1:0] quad;
		logic              updated;
	} result_t;

	// thresholds handed to the core
	typedef struct packed {
		logic [THR_W-1:0] pressure_thr;
		logic [THR_W-1:0] coord_thr;
	} cfg_t;

endpackage

`default_nettype wire

>>> src/tqd_blend.sv
`default_nettype none

// new = trunc((3*base + 4*samp) / 7), signed, divide done by reciprocal multiply
module tqd_blend #(
	parameter int W = tqd_pkg::COORD_W
) (
	input  wire logic [W-1:0] base,
	input  wire logic [W-1:0] samp,
	output logic      [W-1:0] result
);

	localparam int NW = W + 3;   // width of 3*b + 4*s, signed
	localparam int MW = W + 2;   // magnitude width
	localparam int K  = W + 5;   // reciprocal shift, exact while m*err < 2^K
	localparam int PW = MW + K;
	localparam logic [K-1:0] RECIP = K'(((64'd1 << K) / 7) + 64'd1);

	logic [NW-1:0] base_ext;
	logic [NW-1:0] sum;
	logic          neg;
	logic [NW-1:0] sum_abs;
	logic [PW-1:0] prod;
	logic [W-1:0]  quo;

	// weighted sum, two's complement
	assign base_ext = {{3{base[W-1]}}, base};
	assign sum      = base_ext + (base_ext << 1) + {samp[W-1], samp, 2'b00};

	// divide magnitude by seven, restore sign (truncates toward zero)
	assign neg     = sum[NW-1];
	assign sum_abs = neg ? (~sum + NW'(1)) : sum;
	assign prod    = PW'(sum_abs[MW-1:0]) * PW'(RECIP);
	assign quo     = prod[K+W-1:K];
	assign result  = neg ? (~quo + W'(1)) : quo;

endmodule

`default_nettype wire

>>> src/tqd_core.sv
`default_nettype none

// baseline state, pressure gating and quadrant decision for one item per cycle while en is high
module tqd_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire tqd_pkg::item_t item,
	input  wire tqd_pkg::cfg_t  cfg,
	output tqd_pkg::result_t    res
);

	localparam int CW = tqd_pkg::COORD_W;
	localparam int PW = tqd_pkg::PRES_W;
	localparam int TW = tqd_pkg::THR_W;
	localparam int DW = CW + 1;

	logic [CW-1:0] base_x_q;
	logic [CW-1:0] base_y_q;
	logic [PW-1:0] base_p_q;
	logic [tqd_pkg::QUAD_W-1:0] last_quad_q;

	logic [CW-1:0] blend_x;
	logic [CW-1:0] blend_y;
	logic [PW:0]   blend_p;

	logic signed [DW-1:0] dp;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [DW-1:0] pt_s;
	logic signed [DW-1:0] ct_s;
	logic signed [DW-1:0] lim_s;
	logic signed [DW-1:0] band_s;
	logic [TW-3:0]        band;
	logic                 touch;
	logic                 near;
	logic                 xin;
	logic                 yin;
	logic                 do_update;
	logic [tqd_pkg::QUAD_W-1:0] quad;

	// blend units, pressure runs one bit wider so it stays non-negative
	tqd_blend #(.W(CW)) u_blend_x (
		.base   (base_x_q),
		.samp   (item.x),
		.result (blend_x)
	);

	tqd_blend #(.W(CW)) u_blend_y (
		.base   (base_y_q),
		.samp   (item.y),
		.result (blend_y)
	);

	tqd_blend #(.W(PW + 1)) u_blend_p (
		.base   ({1'b0, base_p_q}),
		.samp   ({1'b0, item.p}),
		.result (blend_p)
	);

	// offsets and thresholds
	assign dp     = $signed({1'b0, item.p}) - $signed({1'b0, base_p_q});
	assign dx     = $signed({item.x[CW-1], item.x}) - $signed({base_x_q[CW-1], base_x_q});
	assign dy     = $signed({item.y[CW-1], item.y}) - $signed({base_y_q[CW-1], base_y_q});
	assign pt_s   = $signed({{(DW-TW){1'b0}}, cfg.pressure_thr});
	assign ct_s   = $signed({{(DW-TW){1'b0}}, cfg.coord_thr});
	assign lim_s  = $signed({{(DW-TW-1){1'b0}}, cfg.coord_thr, 1'b0});
	assign band   = (cfg.pressure_thr[TW-1:2] == '0) ? (TW-2)'(1) : cfg.pressure_thr[TW-1:2];
	assign band_s = $signed({{(DW-TW+2){1'b0}}, band});

	assign touch = dp > pt_s;
	assign near  = (dp < band_s) && (dp > -band_s);
	assign xin   = (dx >= -lim_s) && (dx <= lim_s);
	assign yin   = (dy >= -lim_s) && (dy <= lim_s);

	// quadrant decision
	always_comb begin
		quad = tqd_pkg::QUAD_NONE;
		if (item.op == tqd_pkg::OP_CLASSIFY && touch && !(xin && yin)) begin
			if (xin) begin
				quad = (dy > ct_s) ? 3'd3 : 3'd1;
			end else begin
				quad = (dx > ct_s) ? 3'd0 : 3'd2;
			end
		end
	end

	assign do_update = (item.op == tqd_pkg::OP_FORCE) || (!touch && near);

	// result fields
	always_comb begin
		res.quad    = quad;
		res.updated = do_update;
		res.pressed = 1'b0;
		res.button  = 2'd0;
		if (quad != tqd_pkg::QUAD_NONE && quad != last_quad_q) begin
			res.pressed = 1'b1;
			res.button  = quad[1:0];
		end
	end

	// baseline and last quadrant; an empty baseline seeds to the sample,
	// which is what the blend of a sample with itself gives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q    <= '0;
			base_y_q    <= '0;
			base_p_q    <= '0;
			last_quad_q <= tqd_pkg::QUAD_NONE;
		end else if (en) begin
			if (do_update) begin
				if (base_p_q == '0) begin
					base_x_q <= item.x;
					base_y_q <= item.y;
					base_p_q <= item.p;
				end else begin
					base_x_q <= blend_x;
					base_y_q <= blend_y;
					base_p_q <= blend_p[PW-1:0];
				end
			end
			if (item.op == tqd_pkg::OP_CLASSIFY) begin
				last_quad_q <= quad;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/touch_quadrant_detector_top.sv
// An accepted item is held in the input register; its result is then registered in the
// result register and shown on m_*. Throughput: one item per cycle while m_tready drains
// the result register; baseline update and classification both sit between the two registers.
// Reset (arst_n low, asynchronous): both stages empty, baseline zero, last quadrant none,
// pressure_threshold 5, coord_threshold 10.
`default_nettype none

module touch_quadrant_detector_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // sample_x[15:0], sample_y[31:16], sample_pressure[47:32]
	input  wire logic        s_tuser,   // op
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // pressed[0], button[2:1], current_quadrant[5:3],
	                                    // baseline_updated[6], zero[7]
);

	tqd_pkg::item_t   item_s1;
	logic             vld_s1;
	tqd_pkg::result_t res_s2;
	logic             vld_s2;
	tqd_pkg::result_t core_res;
	tqd_pkg::cfg_t    cfg_q;
	logic             adv;
	logic             core_en;

	// pipeline moves when the result register is free or being drained
	assign adv      = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv;
	assign core_en  = vld_s1 && adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressure_thr <= tqd_pkg::PRESSURE_THR_RST;
			cfg_q.coord_thr    <= tqd_pkg::COORD_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tqd_pkg::CFG_PRESSURE_THR: cfg_q.pressure_thr <= cfg_data;
				tqd_pkg::CFG_COORD_THR:    cfg_q.coord_thr    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op <= s_tuser;
			item_s1.x  <= s_tdata[15:0];
			item_s1.y  <= s_tdata[31:16];
			item_s1.p  <= s_tdata[47:32];
		end
	end

	tqd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (core_en),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (core_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (core_en) begin
			res_s2 <= core_res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {1'b0, res_s2.updated, res_s2.quad, res_s2.button, res_s2.pressed};

	// a press always names the quadrant it reports
	a_press_quad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tdata[5:3] != tqd_pkg::QUAD_NONE)
			&& (m_tdata[2:1] == m_tdata[4:3]))
		else $error("press without matching quadrant");

	// a baseline update never coincides with a press or a quadrant
	a_update_no_touch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> !m_tdata[0] && (m_tdata[5:3] == tqd_pkg::QUAD_NONE))
		else $error("baseline update on a touched sample");

	// no press means button reads zero
	a_button_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[2:1] == 2'd0))
		else $error("button set without a press");

	// the core only steps when an item is held in the input register, and each step loads a valid result
	a_core_step: assert property (@(posedge clk) disable iff (!arst_n)
		core_en |=> vld_s2)
		else $error("core stepped without a result");

endmodule

`default_nettype wire
